// ===== rtl/bbd_pkg.sv =====
// Package for the box downscaler: payload structs, register indexes, state codes.
// No dependencies.
package bbd_pkg;

  typedef struct packed {
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pix_in_t;

  typedef struct packed {
    logic [7:0]  out_red;
    logic [7:0]  out_green;
    logic [7:0]  out_blue;
    logic [11:0] out_col;
    logic [11:0] out_row;
    logic        frame_end;
  } pix_out_t;

  localparam logic [2:0] REG_SRC_WIDTH  = 3'd0;
  localparam logic [2:0] REG_SRC_HEIGHT = 3'd1;
  localparam logic [2:0] REG_DST_WIDTH  = 3'd2;
  localparam logic [2:0] REG_DST_HEIGHT = 3'd3;
  localparam logic [2:0] REG_GRAY_MODE  = 3'd4;

  localparam int SUM_W  = 24;
  localparam int AREA_W = 16;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_DIV,
    ST_GRAY,
    ST_OUT
  } state_t;

endpackage

// ===== rtl/bresenham_box_downscaler.sv =====
// Top level of the Bresenham box downscaler: stepping, column store, divider.
// Depends on bbd_pkg.
//
// Takes one source pixel at a time in raster order. A pixel that ends no run
// is taken without a stall. A pixel that ends a run stalls the input through
// the read state, while the column store entry read at the accept is summed
// and written back. A pixel that completes a destination rectangle instead
// starts three parallel bit-serial dividers for the channel sums against the
// area, followed in gray mode by a step for the mean of three by reciprocal
// multiplication. The result is then offered until it is taken. Configuration
// is taken only while the block is idle. The column store holds three 24-bit
// sums per destination column and needs no clearing.
module bresenham_box_downscaler #(
  parameter int MAX_DST_SIZE = 4096,
  parameter int MAX_RUN      = 255
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  bbd_pkg::pix_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bbd_pkg::pix_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [12:0]       cfg_data
);

  localparam int IDX_W = (MAX_DST_SIZE > 1) ? $clog2(MAX_DST_SIZE) : 1;
  localparam int SW    = bbd_pkg::SUM_W;

  // Registers
  logic [12:0] src_width, src_height, dst_width, dst_height;
  logic        gray_mode;

  // Stepping state
  logic [SW-1:0] run_r, run_g, run_b;
  logic signed [15:0] h_err, v_err;
  logic [12:0] h_pos, v_pos;
  logic [7:0]  h_len, v_len;
  logic [11:0] out_col_q, out_row_q;

  // Column store
  logic [3*SW-1:0] col_mem [MAX_DST_SIZE];
  logic [3*SW-1:0] col_rd;
  logic [IDX_W-1:0] col_idx;

  // Pending run
  logic [SW-1:0] pend_r, pend_g, pend_b;
  logic          pend_add, pend_vend, pend_fend;
  logic [7:0]    pend_hlen, pend_vlen;
  logic [11:0]   pend_col, pend_row;

  // Divider
  logic [SW-1:0] q_r, q_g, q_b;
  logic [bbd_pkg::AREA_W+1:0] rem_r, rem_g, rem_b;
  logic [bbd_pkg::AREA_W-1:0] area;
  logic [4:0]    div_cnt;
  logic [9:0]    gsum;
  logic [18:0]   gprod;
  logic [7:0]    gmean;

  bbd_pkg::state_t state, state_next;
  bbd_pkg::pix_out_t out_q;

  logic [12:0] w_eff, h_eff;
  logic row_end, last_row, h_end, v_end, h_err_ge, v_err_ge;
  logic [7:0] hlen, vlen;
  logic in_acc, cfg_acc, size_wr;
  logic [SW-1:0] add_r, add_g, add_b;

  assign w_eff    = (src_width == '0) ? 13'd1 : src_width;
  assign h_eff    = (src_height == '0) ? 13'd1 : src_height;
  assign hlen     = h_len + 8'd1;
  assign vlen     = v_len + 8'd1;
  assign row_end  = h_pos >= (w_eff - 13'd1);
  assign last_row = v_pos >= (h_eff - 13'd1);
  assign h_err_ge = ~h_err[15];
  assign v_err_ge = ~v_err[15];
  assign h_end    = h_err_ge || (hlen >= 8'(MAX_RUN)) || row_end;
  assign v_end    = v_err_ge || (vlen >= 8'(MAX_RUN)) || last_row;
  assign in_acc   = in_valid && !in_stall;
  assign cfg_ready = (state == bbd_pkg::ST_IDLE);
  assign cfg_acc  = cfg_valid && cfg_ready;
  assign size_wr  = cfg_acc && (cfg_index <= bbd_pkg::REG_DST_HEIGHT);
  assign col_idx  = IDX_W'(out_col_q);

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      bbd_pkg::ST_IDLE: if (in_acc && h_end) state_next = bbd_pkg::ST_READ;
      bbd_pkg::ST_READ: state_next = pend_vend ? bbd_pkg::ST_DIV : bbd_pkg::ST_IDLE;
      bbd_pkg::ST_DIV:  if (div_cnt == 5'd0)
                          state_next = gray_mode ? bbd_pkg::ST_GRAY : bbd_pkg::ST_OUT;
      bbd_pkg::ST_GRAY: state_next = bbd_pkg::ST_OUT;
      bbd_pkg::ST_OUT:  if (!out_stall) state_next = bbd_pkg::ST_IDLE;
      default:          state_next = bbd_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_stall  = (state != bbd_pkg::ST_IDLE);
    out_valid = (state == bbd_pkg::ST_OUT);
    out_data  = out_q;
  end

  always_ff @(posedge clk) begin
    if (rst) state <= bbd_pkg::ST_IDLE;
    else     state <= state_next;
  end

  // Column store: read at accept, write back in the next cycle
  always_ff @(posedge clk) begin
    if (in_acc && h_end) col_rd <= col_mem[col_idx];
    if (state == bbd_pkg::ST_READ && !pend_vend)
      col_mem[IDX_W'(pend_col)] <= {add_r, add_g, add_b};
  end

  assign add_r = pend_add ? pend_r + col_rd[3*SW-1:2*SW] : pend_r;
  assign add_g = pend_add ? pend_g + col_rd[2*SW-1:SW]   : pend_g;
  assign add_b = pend_add ? pend_b + col_rd[SW-1:0]      : pend_b;

  // Registers and stepping
  always_ff @(posedge clk) begin
    if (rst || size_wr || (in_acc && row_end && last_row)) begin
      if (rst) begin
        src_width <= 13'd1; src_height <= 13'd1;
        dst_width <= 13'd1; dst_height <= 13'd1;
        gray_mode <= 1'b0;
        h_err <= 16'sd1; v_err <= 16'sd1;
      end else if (size_wr) begin
        unique case (cfg_index)
          bbd_pkg::REG_SRC_WIDTH: begin
            src_width <= cfg_data;
            h_err <= $signed({2'b0, dst_width, 1'b0})
                   - $signed({3'b0, ((cfg_data == '0) ? 13'd1 : cfg_data)});
            v_err <= $signed({2'b0, dst_height, 1'b0}) - $signed({3'b0, h_eff});
          end
          bbd_pkg::REG_SRC_HEIGHT: begin
            src_height <= cfg_data;
            h_err <= $signed({2'b0, dst_width, 1'b0}) - $signed({3'b0, w_eff});
            v_err <= $signed({2'b0, dst_height, 1'b0})
                   - $signed({3'b0, ((cfg_data == '0) ? 13'd1 : cfg_data)});
          end
          bbd_pkg::REG_DST_WIDTH: begin
            dst_width <= cfg_data;
            h_err <= $signed({2'b0, cfg_data, 1'b0}) - $signed({3'b0, w_eff});
            v_err <= $signed({2'b0, dst_height, 1'b0}) - $signed({3'b0, h_eff});
          end
          default: begin
            dst_height <= cfg_data;
            h_err <= $signed({2'b0, dst_width, 1'b0}) - $signed({3'b0, w_eff});
            v_err <= $signed({2'b0, cfg_data, 1'b0}) - $signed({3'b0, h_eff});
          end
        endcase
      end else begin
        h_err <= $signed({2'b0, dst_width, 1'b0}) - $signed({3'b0, w_eff});
        v_err <= $signed({2'b0, dst_height, 1'b0}) - $signed({3'b0, h_eff});
      end
      run_r <= '0; run_g <= '0; run_b <= '0;
      h_pos <= '0; v_pos <= '0; h_len <= '0; v_len <= '0;
      out_col_q <= '0; out_row_q <= '0;
    end else begin
      if (in_acc) begin
        if (h_end) begin
          run_r <= '0; run_g <= '0; run_b <= '0;
          h_len <= '0;
        end else begin
          run_r <= run_r + SW'(in_data.in_red);
          run_g <= run_g + SW'(in_data.in_green);
          run_b <= run_b + SW'(in_data.in_blue);
          h_len <= hlen;
        end
        if (!row_end) begin
          h_pos <= h_pos + 13'd1;
          // A target no smaller than the source keeps the error non-negative;
          // hold it there so it cannot grow out of range
          if (dst_width < w_eff)
            h_err <= h_err + $signed({2'b0, dst_width, 1'b0})
                   - (h_err_ge ? $signed({2'b0, w_eff, 1'b0}) : 16'sd0);
          if (h_end) out_col_q <= out_col_q + 12'd1;
        end else begin
          h_pos <= '0;
          h_err <= $signed({2'b0, dst_width, 1'b0}) - $signed({3'b0, w_eff});
          out_col_q <= '0;
          v_pos <= v_pos + 13'd1;
          if (dst_height < h_eff)
            v_err <= v_err + $signed({2'b0, dst_height, 1'b0})
                   - (v_err_ge ? $signed({2'b0, h_eff, 1'b0}) : 16'sd0);
          if (v_end) begin
            v_len <= '0;
            out_row_q <= out_row_q + 12'd1;
          end else begin
            v_len <= vlen;
          end
        end
      end
    end
    // Gray mode does not restart the frame
    if (!rst && cfg_acc && cfg_index == bbd_pkg::REG_GRAY_MODE) gray_mode <= cfg_data[0];
  end

  // Capture the finished run
  always_ff @(posedge clk) begin
    if (in_acc && h_end) begin
      pend_r    <= run_r + SW'(in_data.in_red);
      pend_g    <= run_g + SW'(in_data.in_green);
      pend_b    <= run_b + SW'(in_data.in_blue);
      pend_add  <= (v_len != 8'd0);
      pend_vend <= v_end;
      pend_fend <= row_end && last_row;
      pend_hlen <= hlen;
      pend_vlen <= vlen;
      pend_col  <= out_col_q;
      pend_row  <= out_row_q;
    end
  end

  // Mean of the three quotients: multiply by 683/2048, exact for sums up to 765
  assign gsum  = 10'(q_r[7:0]) + 10'(q_g[7:0]) + 10'(q_b[7:0]);
  assign gprod = 19'(gsum) * 19'd683;
  assign gmean = gprod[18:11];

  // Restoring division: three channels against the area
  always_ff @(posedge clk) begin
    unique case (state)
      bbd_pkg::ST_READ: begin
        q_r <= add_r; q_g <= add_g; q_b <= add_b;
        rem_r <= '0; rem_g <= '0; rem_b <= '0;
        area <= 16'(pend_hlen) * 16'(pend_vlen);
        div_cnt <= 5'(SW - 1);
      end
      bbd_pkg::ST_DIV: begin
        if ({rem_r[bbd_pkg::AREA_W:0], q_r[SW-1]} >= {2'b0, area}) begin
          rem_r <= {rem_r[bbd_pkg::AREA_W:0], q_r[SW-1]} - {2'b0, area};
          q_r   <= {q_r[SW-2:0], 1'b1};
        end else begin
          rem_r <= {rem_r[bbd_pkg::AREA_W:0], q_r[SW-1]};
          q_r   <= {q_r[SW-2:0], 1'b0};
        end
        if ({rem_g[bbd_pkg::AREA_W:0], q_g[SW-1]} >= {2'b0, area}) begin
          rem_g <= {rem_g[bbd_pkg::AREA_W:0], q_g[SW-1]} - {2'b0, area};
          q_g   <= {q_g[SW-2:0], 1'b1};
        end else begin
          rem_g <= {rem_g[bbd_pkg::AREA_W:0], q_g[SW-1]};
          q_g   <= {q_g[SW-2:0], 1'b0};
        end
        if ({rem_b[bbd_pkg::AREA_W:0], q_b[SW-1]} >= {2'b0, area}) begin
          rem_b <= {rem_b[bbd_pkg::AREA_W:0], q_b[SW-1]} - {2'b0, area};
          q_b   <= {q_b[SW-2:0], 1'b1};
        end else begin
          rem_b <= {rem_b[bbd_pkg::AREA_W:0], q_b[SW-1]};
          q_b   <= {q_b[SW-2:0], 1'b0};
        end
        if (div_cnt != 5'd0) div_cnt <= div_cnt - 5'd1;
      end
      default: ;
    endcase
  end

  // Result register
  always_ff @(posedge clk) begin
    if (state == bbd_pkg::ST_DIV && div_cnt == 5'd0 && !gray_mode) begin
      out_q.out_red   <= {q_r[6:0], ({rem_r[bbd_pkg::AREA_W:0], q_r[SW-1]} >= {2'b0, area})};
      out_q.out_green <= {q_g[6:0], ({rem_g[bbd_pkg::AREA_W:0], q_g[SW-1]} >= {2'b0, area})};
      out_q.out_blue  <= {q_b[6:0], ({rem_b[bbd_pkg::AREA_W:0], q_b[SW-1]} >= {2'b0, area})};
    end else if (state == bbd_pkg::ST_GRAY) begin
      out_q.out_red   <= gmean;
      out_q.out_green <= gmean;
      out_q.out_blue  <= gmean;
    end
    if (state == bbd_pkg::ST_READ) begin
      out_q.out_col   <= pend_col;
      out_q.out_row   <= pend_row;
      out_q.frame_end <= pend_fend;
    end
  end

  // Checks
  a_no_out_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_valid || in_stall) else $error("input taken during output");
  a_hold_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid) else $error("result dropped");
  a_read_after: assert property (@(posedge clk) disable iff (rst)
    (state == bbd_pkg::ST_READ) |-> $past(in_acc)) else $error("stray store read");

endmodule

// ===== tb/tb_bresenham_box_downscaler.sv =====
// Self-checking testbench for bresenham_box_downscaler: directed and random frames.
// Depends on bbd_pkg and the downscaler RTL; carries its own predictor of the block.
`timescale 1ns / 100ps

module tb_bresenham_box_downscaler;

  localparam int STORE_DEPTH = 4096;
  localparam int RUN_LIMIT   = 255;
  localparam int CYCLE_LIMIT = 4000000;
  localparam int SETTLE      = 64;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  bbd_pkg::pix_in_t   in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  bbd_pkg::pix_out_t  out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index = bbd_pkg::REG_SRC_WIDTH;
  logic [12:0]        cfg_data = '0;

  bresenham_box_downscaler DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Predictor state: registers, column store and stepping
  int unsigned reg_src_w, reg_src_h, reg_dst_w, reg_dst_h, reg_gray;
  logic [23:0] col_red [STORE_DEPTH];
  logic [23:0] col_green [STORE_DEPTH];
  logic [23:0] col_blue [STORE_DEPTH];
  int unsigned acc_red, acc_green, acc_blue;
  int          h_err, v_err;
  int unsigned h_pos, h_len, out_col_now, v_pos, v_len, out_row_now;

  bbd_pkg::pix_out_t expected_pixels[$];
  int          mismatches = 0;
  int          pixels_sent = 0;
  int          pixels_checked = 0;
  int          frames_done = 0;
  int          cycles = 0;
  bit          calm = 1'b0;

  function automatic int unsigned eff(int unsigned v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic void restart_stepping();
    acc_red = 0; acc_green = 0; acc_blue = 0;
    h_err = int'(2 * reg_dst_w) - int'(eff(reg_src_w));
    h_pos = 0; h_len = 0; out_col_now = 0;
    v_err = int'(2 * reg_dst_h) - int'(eff(reg_src_h));
    v_pos = 0; v_len = 0; out_row_now = 0;
  endfunction

  function automatic void apply_register(logic [2:0] idx, logic [12:0] val);
    case (idx)
      bbd_pkg::REG_SRC_WIDTH:  begin reg_src_w = val; restart_stepping(); end
      bbd_pkg::REG_SRC_HEIGHT: begin reg_src_h = val; restart_stepping(); end
      bbd_pkg::REG_DST_WIDTH:  begin reg_dst_w = val; restart_stepping(); end
      bbd_pkg::REG_DST_HEIGHT: begin reg_dst_h = val; restart_stepping(); end
      bbd_pkg::REG_GRAY_MODE:  reg_gray = val[0];
      default: ;
    endcase
  endfunction

  // Accumulate one source pixel and queue the destination pixel it completes
  function automatic void downscale_pixel(bbd_pkg::pix_in_t p);
    int unsigned w, h, hl, vl, idx, r, g, b, area, m;
    bit row_end, last_row, h_end, v_end;
    bbd_pkg::pix_out_t res;
    w = eff(reg_src_w);
    h = eff(reg_src_h);
    hl = h_len + 1;
    vl = v_len + 1;
    row_end = h_pos >= w - 1;
    last_row = v_pos >= h - 1;
    h_end = h_err >= 0 || hl >= RUN_LIMIT || row_end;
    v_end = v_err >= 0 || vl >= RUN_LIMIT || last_row;
    acc_red = (acc_red + p.in_red) & 24'hffffff;
    acc_green = (acc_green + p.in_green) & 24'hffffff;
    acc_blue = (acc_blue + p.in_blue) & 24'hffffff;
    if (h_err >= 0) h_err -= int'(2 * w);
    h_err += int'(2 * reg_dst_w);
    if (h_end) begin
      idx = out_col_now % STORE_DEPTH;
      r = acc_red; g = acc_green; b = acc_blue;
      if (v_len != 0) begin
        r = (r + col_red[idx]) & 24'hffffff;
        g = (g + col_green[idx]) & 24'hffffff;
        b = (b + col_blue[idx]) & 24'hffffff;
      end
      if (v_end) begin
        area = hl * vl;
        r /= area; g /= area; b /= area;
        if (reg_gray != 0) begin
          m = (r + g + b) / 3;
          r = m; g = m; b = m;
        end
        res.out_red = r[7:0];
        res.out_green = g[7:0];
        res.out_blue = b[7:0];
        res.out_col = out_col_now[11:0];
        res.out_row = out_row_now[11:0];
        res.frame_end = row_end && last_row;
        expected_pixels.push_back(res);
      end else begin
        col_red[idx] = r[23:0]; col_green[idx] = g[23:0]; col_blue[idx] = b[23:0];
      end
      acc_red = 0; acc_green = 0; acc_blue = 0;
      h_len = 0;
      out_col_now = (out_col_now + 1) & 12'hfff;
    end else begin
      h_len = hl;
    end
    if (!row_end) begin
      h_pos++;
    end else if (last_row) begin
      restart_stepping();
      frames_done++;
    end else begin
      h_pos = 0;
      h_err = int'(2 * reg_dst_w) - int'(w);
      h_len = 0;
      out_col_now = 0;
      if (v_err >= 0) v_err -= int'(2 * h);
      v_err += int'(2 * reg_dst_h);
      if (v_end) begin
        v_len = 0;
        out_row_now = (out_row_now + 1) & 12'hfff;
      end else begin
        v_len = vl;
      end
      v_pos++;
    end
  endfunction

  // Clock, cycle limit
  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               expected_pixels.size());
      $display("tb_bresenham_box_downscaler NOT OK");
      $finish;
    end
  end

  // Hold off results in random bursts
  int stall_left = 0;
  always @(negedge clk) begin
    if (calm || rst) begin
      out_stall = 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 11);
      out_stall = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    bbd_pkg::pix_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result col %0d row %0d", out_data.out_col, out_data.out_row);
      end else begin
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (out_data.out_red !== want.out_red || out_data.out_green !== want.out_green ||
            out_data.out_blue !== want.out_blue || out_data.out_col !== want.out_col ||
            out_data.out_row !== want.out_row || out_data.frame_end !== want.frame_end) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: expected rgb %02h %02h %02h col %0d row %0d end %0b,",
                      " got rgb %02h %02h %02h col %0d row %0d end %0b"},
                     want.out_red, want.out_green, want.out_blue, want.out_col,
                     want.out_row, want.frame_end, out_data.out_red, out_data.out_green,
                     out_data.out_blue, out_data.out_col, out_data.out_row,
                     out_data.frame_end);
        end
      end
    end
  end

  // Send one item, then idle for a random burst now and then
  task automatic send_pixel(bbd_pkg::pix_in_t p);
    in_data = p;
    in_valid = 1'b1;
    while (in_stall) @(negedge clk);
    @(posedge clk);
    downscale_pixel(p);
    pixels_sent++;
    @(negedge clk);
    in_valid = 1'b0;
    if (!calm && $urandom_range(0, 7) == 0)
      repeat ($urandom_range(1, 12)) @(negedge clk);
  endtask

  function automatic bbd_pkg::pix_in_t random_pixel();
    bbd_pkg::pix_in_t p;
    p = 24'($urandom);
    return p;
  endfunction

  // Wait until every result is in and the block has gone quiet
  task automatic drain();
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [12:0] val);
    drain();
    cfg_index = idx;
    cfg_data = val;
    cfg_valid = 1'b1;
    while (!cfg_ready) @(negedge clk);
    @(posedge clk);
    apply_register(idx, val);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_sizes(int sw, int sh, int dw, int dh);
    write_reg(bbd_pkg::REG_SRC_WIDTH, sw[12:0]);
    write_reg(bbd_pkg::REG_SRC_HEIGHT, sh[12:0]);
    write_reg(bbd_pkg::REG_DST_WIDTH, dw[12:0]);
    write_reg(bbd_pkg::REG_DST_HEIGHT, dh[12:0]);
  endtask

  task automatic send_frame(int n);
    repeat (n) send_pixel(random_pixel());
  endtask

  // Reset defaults: every pixel is its own 1x1 frame
  task automatic test_reset_defaults();
    send_pixel('{8'h00, 8'h00, 8'h00});
    send_pixel('{8'hff, 8'hff, 8'hff});
    send_pixel('{8'hff, 8'h00, 8'h5a});
  endtask

  // Field extremes, gray mode, zero and oversized targets, ignored indexes
  task automatic test_directed_extremes();
    set_sizes(4, 3, 2, 2);
    repeat (12) send_pixel('{8'hff, 8'hff, 8'hff});
    write_reg(bbd_pkg::REG_GRAY_MODE, 13'd1);
    send_frame(12);
    write_reg(bbd_pkg::REG_GRAY_MODE, 13'h1ffe);
    write_reg(3'd5, 13'h1fff);
    write_reg(3'd6, 13'd0);
    write_reg(3'd7, 13'd7);
    set_sizes(0, 0, 0, 0);
    send_frame(2);
    set_sizes(3, 2, 4096, 4096);
    send_frame(6);
    set_sizes(5, 4, 0, 1);
    send_frame(20);
  endtask

  // Horizontal and vertical run saturation past the longest run
  task automatic test_run_saturation();
    set_sizes(300, 1, 1, 1);
    send_frame(300);
    set_sizes(1, 300, 1, 1);
    write_reg(bbd_pkg::REG_GRAY_MODE, 13'd1);
    send_frame(300);
    set_sizes(2, 300, 2, 1);
    write_reg(bbd_pkg::REG_GRAY_MODE, 13'd0);
    send_frame(600);
  endtask

  // A size write mid-frame restarts the stepping
  task automatic test_frame_restart();
    set_sizes(7, 5, 3, 2);
    send_frame(17);
    write_reg(bbd_pkg::REG_DST_WIDTH, 13'd2);
    send_frame(35);
  endtask

  // Random frames; sender pauses for a full drain at least once
  task automatic test_random_frames();
    int sw, sh, pick, n;
    bit drained;
    drained = 1'b0;
    while (pixels_sent < 1800) begin
      if (pixels_sent > 1500) calm = 1'b1;
      sw = $urandom_range(1, 24);
      sh = $urandom_range(1, 12);
      pick = $urandom_range(0, 9);
      set_sizes(sw, sh, (pick == 0) ? 0 : (pick == 1) ? sw + 3 : $urandom_range(1, sw),
                (pick == 2) ? 0 : $urandom_range(1, sh));
      write_reg(bbd_pkg::REG_GRAY_MODE, 13'($urandom_range(0, 1)));
      n = sw * sh;
      repeat ($urandom_range(1, 2)) begin
        if ($urandom_range(0, 7) == 0) n = $urandom_range(1, sw * sh);
        send_frame(n / 2);
        if (!drained || $urandom_range(0, 5) == 0) begin
          drained = 1'b1;
          while (expected_pixels.size() != 0) @(negedge clk);
        end
        send_frame(n - n / 2);
      end
    end
  endtask

  initial begin
    reg_src_w = 1; reg_src_h = 1; reg_dst_w = 1; reg_dst_h = 1; reg_gray = 0;
    restart_stepping();
    repeat (12) @(negedge clk);
    rst = 1'b0;
    test_reset_defaults();
    test_directed_extremes();
    test_run_saturation();
    test_frame_restart();
    test_random_frames();
    drain();
    $display("sent %0d source pixels over %0d full frames, checked %0d destination pixels",
             pixels_sent, frames_done, pixels_checked);
    $display("covered reset sizes, gray mode, run saturation, edge clipping, restarts");
    if (mismatches == 0) begin
      $display("tb_bresenham_box_downscaler OK");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("tb_bresenham_box_downscaler NOT OK");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/bbd_pkg.sv
rtl/bresenham_box_downscaler.sv
tb/tb_bresenham_box_downscaler.sv
